>>> rtl/halton_jitter_generator_core_assert.svh
// Assertion macros used by the core RTL file of the jitter generator.
`ifndef HALTON_JITTER_GENERATOR_CORE_ASSERT_SVH
`define HALTON_JITTER_GENERATOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define HJG_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is high.
`define HJG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

>>> rtl/hjg_pkg.sv
`default_nettype none

package hjg_pkg;

   // Default configuration values.
   localparam int FRAC_BITS_DEFAULT = 16;
   localparam logic [7:0] PHASE_COUNT_RESET = 8'd8;

   // Fixed datapath widths.
   localparam int FRAME_W = 32;
   localparam int SEQ_W = 8;
   localparam int DEN_W = 10;
   localparam int CNT_W = 5;
   localparam int CS_WIDTH = 11;

   // Result of the shared compare and subtract unit.
   typedef struct packed {
      logic                ge;
      logic [CS_WIDTH-1:0] diff;
   } cs_result_type;

endpackage

`default_nettype wire

>>> rtl/halton_jitter_generator_core.sv
`default_nettype none
//  Channel   Direction  Handshake           Payload
//  req_      in         req_valid/req_stall  req_frame_index[31:0]
//  rsp_      out        rsp_valid/rsp_stall  rsp_jitter_x[15:0], rsp_jitter_y[15:0]
//  csr_      in         csr_valid/csr_ready  csr_data[7:0] (phase count)
//
//  One request passes an accept step, the modulo steps, one digit step per base-3
//  digit of the sequence index (1 to 6 digits), the fraction steps and a done step.
//  The 32 modulo steps and the FRAC_BITS fraction steps share one compare and
//  subtract unit, one bit per cycle; the digit loop takes one digit per cycle.
//  Reset is synchronous and active high; it restores the phase count to 8.
//  A finished result sits in the output register, so a new request is taken
//  while the previous result is stalled; a second result waits in the last step.
`include "halton_jitter_generator_core_assert.svh"

module halton_jitter_generator_core #(
   parameter int FRAC_BITS = hjg_pkg::FRAC_BITS_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [31:0]         req_frame_index,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic signed [15:0]       rsp_jitter_x,
   output logic signed [15:0]       rsp_jitter_y,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [7:0]          csr_data
);
   import hjg_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOD,
      ST_DIGIT,
      ST_FRAC,
      ST_DONE
   } state_type;

   // One half in the format of the centered value.
   localparam logic signed [FRAC_BITS+1:0] HALF =
      signed'((FRAC_BITS+2)'(1 << (FRAC_BITS - 1)));

   state_type             state_ff, state_in;
   logic [7:0]            phase_ff, phase_in;
   logic [FRAME_W-1:0]    frame_ff, frame_in;
   logic [7:0]            div_ff, div_in;
   logic [DEN_W-1:0]      rem_ff, rem_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [SEQ_W-1:0]      seq_ff, seq_in;
   logic [SEQ_W-1:0]      n3_ff, n3_in;
   logic [DEN_W-1:0]      num3_ff, num3_in;
   logic [DEN_W-1:0]      den3_ff, den3_in;
   logic [FRAC_BITS-1:0]  quot_ff, quot_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [15:0]           jx_ff, jx_in;
   logic [15:0]           jy_ff, jy_in;

   logic [CS_WIDTH-1:0]   cs_a, cs_b;
   cs_result_type         cs_result;
   logic                  load_out;
   logic [7:0]            p_eff;
   logic [15:0]           prod3;
   logic [SEQ_W-1:0]      q3;
   logic [1:0]            d3;
   logic [SEQ_W-1:0]      rev8;
   logic [FRAC_BITS-1:0]  frac_x;

   // Center a truncated fraction around zero and clamp it to 16 bits.
   function automatic logic [15:0] center(input logic [FRAC_BITS-1:0] frac);
      logic signed [FRAC_BITS+1:0] v;
      logic signed [31:0]          w;
      v = signed'({2'b00, frac}) - HALF;
      w = 32'(v);
      if (w > 32'sd32767) begin
         w = 32'sd32767;
      end else if (w < -32'sd32768) begin
         w = -32'sd32768;
      end
      return 16'(w);
   endfunction

   hjg_cmpsub u_cmpsub (
      .cs_a      (cs_a),
      .cs_b      (cs_b),
      .cs_result (cs_result)
   );

   // A zero phase count behaves as a cycle of length one.
   assign p_eff = (phase_ff == 8'd0) ? 8'd1 : phase_ff;

   // The base-2 radical inverse of an 8-bit index is its bit reversal over 256.
   always_comb begin
      for (int i = 0; i < SEQ_W; i++) begin
         rev8[i] = seq_ff[SEQ_W-1-i];
      end
   end
   assign frac_x = FRAC_BITS'(rev8) << (FRAC_BITS - SEQ_W);

   // Division of the remaining index by three: x * 171 >> 9 is exact below 256.
   assign prod3 = 16'(n3_ff) * 16'd171;
   assign q3 = SEQ_W'(prod3 >> 9);
   assign d3 = 2'(n3_ff - SEQ_W'(q3 * 8'd3));

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      frame_in = frame_ff;
      div_in = div_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      seq_in = seq_ff;
      n3_in = n3_ff;
      num3_in = num3_ff;
      den3_in = den3_ff;
      quot_in = quot_ff;
      jx_in = jx_ff;
      jy_in = jy_ff;
      cs_a = '0;
      cs_b = '0;
      load_out = 1'b0;

      if (csr_valid) begin
         phase_in = csr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               frame_in = req_frame_index;
               div_in = p_eff;
               rem_in = '0;
               cnt_in = CNT_W'(FRAME_W - 1);
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            // Restoring modulo: shift in one frame bit and subtract if it fits.
            cs_a = CS_WIDTH'({rem_ff[7:0], frame_ff[FRAME_W-1]});
            cs_b = CS_WIDTH'(div_ff);
            rem_in = DEN_W'(cs_result.ge ? cs_result.diff : cs_a);
            frame_in = frame_ff << 1;
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               seq_in = SEQ_W'(rem_in[7:0] + 8'd1);
               n3_in = SEQ_W'(rem_in[7:0] + 8'd1);
               num3_in = '0;
               den3_in = DEN_W'(1);
               state_in = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            // Peel one base-3 digit and append it to the mirrored numerator.
            num3_in = DEN_W'(num3_ff * DEN_W'(3) + DEN_W'(d3));
            den3_in = DEN_W'(den3_ff * DEN_W'(3));
            n3_in = q3;
            if (q3 == '0) begin
               rem_in = num3_in;
               cnt_in = CNT_W'(FRAC_BITS - 1);
               quot_in = '0;
               state_in = ST_FRAC;
            end
         end
         ST_FRAC: begin
            // Long division of num / 3^k, one fraction bit per cycle.
            cs_a = CS_WIDTH'({rem_ff, 1'b0});
            cs_b = CS_WIDTH'(den3_ff);
            rem_in = DEN_W'(cs_result.ge ? cs_result.diff : cs_a);
            quot_in = {quot_ff[FRAC_BITS-2:0], cs_result.ge};
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load_out = 1'b1;
               jx_in = center(frac_x);
               jy_in = center(quot_ff);
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = (rsp_valid_ff & rsp_stall) | load_out;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PHASE_COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      frame_ff <= frame_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      seq_ff <= seq_in;
      n3_ff <= n3_in;
      num3_ff <= num3_in;
      den3_ff <= den3_in;
      quot_ff <= quot_in;
      jx_ff <= jx_in;
      jy_ff <= jy_in;
   end

   // Configuration is taken at any time; the user must write it only while idle, the block does not enforce it.
   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_jitter_x = signed'(jx_ff);
   assign rsp_jitter_y = signed'(jy_ff);

   // An accepted request always starts the modulo pass.
   `HJG_ASSERT_NEXT(a_accept_starts_mod, clock, reset, req_valid && !req_stall, state_ff == ST_MOD)
   // The modulo remainder stays below the latched divisor.
   `HJG_ASSERT_IMPL(a_mod_rem_below_div, clock, reset, state_ff == ST_MOD, rem_ff < 10'(div_ff))
   // The mirrored base-3 numerator is a proper fraction of its denominator.
   `HJG_ASSERT_IMPL(a_digit_num_below_den, clock, reset, state_ff == ST_DIGIT, num3_ff < den3_ff)
   // The division remainder stays below the denominator.
   `HJG_ASSERT_IMPL(a_frac_rem_below_den, clock, reset, state_ff == ST_FRAC, rem_ff < den3_ff)

endmodule

`default_nettype wire

>>> rtl/hjg_cmpsub.sv
`default_nettype none

module hjg_cmpsub (
   input  wire logic [hjg_pkg::CS_WIDTH-1:0] cs_a,
   input  wire logic [hjg_pkg::CS_WIDTH-1:0] cs_b,
   output hjg_pkg::cs_result_type            cs_result
);
   import hjg_pkg::*;

   logic [CS_WIDTH:0] wide_diff;

   // A borrow out of the top bit means the divisor did not fit.
   assign wide_diff = {1'b0, cs_a} - {1'b0, cs_b};
   assign cs_result.ge = ~wide_diff[CS_WIDTH];
   assign cs_result.diff = wide_diff[CS_WIDTH-1:0];

endmodule

`default_nettype wire
